// ----- hw/rtl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants and types of the postfix expression evaluator: stack
// sizing, status codes, character codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int WORD_W      = 32;
  localparam int STEP_W      = $clog2(WORD_W);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_ADD  = 8'd43;
  localparam logic [7:0] CH_SUB  = 8'd45;
  localparam logic [7:0] CH_MUL  = 8'd42;
  localparam logic [7:0] CH_DIV  = 8'd47;
  localparam logic [7:0] CH_MOD  = 8'd37;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic push;
    logic flag_over;
    logic flag_under;
    logic flag_divz;
    logic rd_top;
    logic rd_second;
    logic cap_rhs;
    logic cap_lhs;
    logic alu_take;
    logic div_start;
    logic div_take;
    logic write_res;
    logic emit;
  } pfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_divop;
    logic full;
    logic lt2;
    logic rhs_zero;
    logic div_done;
    logic last;
    logic out_free;
  } pfe_sts_t;

endpackage

// ----- hw/rtl/pfe_div.sv -----
// ----------------------------------------------------------------------------
// pfe_div
// Iterative signed divider, one quotient bit per cycle. Quotient and
// remainder truncate toward zero; the most negative value over minus one
// wraps.
// ----------------------------------------------------------------------------
module pfe_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pfe_pkg::WORD_W-1:0] dividend,
  input  logic [pfe_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [pfe_pkg::WORD_W-1:0] quot,
  output logic [pfe_pkg::WORD_W-1:0] remd
);
  import pfe_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] dvs_r;
  logic              qneg_r;
  logic              rneg_r;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] abs_a;
  logic [WORD_W-1:0] abs_b;

  assign abs_a   = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
  assign abs_b   = divisor[WORD_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= abs_a;
      rem_r  <= '0;
      dvs_r  <= abs_b;
      qneg_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      rneg_r <= dividend[WORD_W-1];
    end else if (busy_r) begin
      // Restoring step: the partial remainder always stays below the divisor.
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = qneg_r ? (~quo_r + 1'b1) : quo_r;
  assign remd = rneg_r ? (~rem_r + 1'b1) : rem_r;

endmodule

// ----- hw/rtl/pfe_dp.sv -----
// ----------------------------------------------------------------------------
// pfe_dp
// Datapath: captured request, operand stack memory with registered read,
// stack count, sticky error, operand registers, ALU, divider and the result
// output register.
// ----------------------------------------------------------------------------
module pfe_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfe_pkg::pfe_cmd_t           cmd,
  output pfe_pkg::pfe_sts_t           sts,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_end_of_expr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_value,
  output logic [1:0]                  out_status
);
  import pfe_pkg::*;

  logic [7:0]        char_r;
  logic              last_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        err_r;
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_q_r;
  logic [WORD_W-1:0] rhs_r;
  logic [WORD_W-1:0] lhs_r;
  logic [WORD_W-1:0] res_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_value_r;
  logic [1:0]        out_status_r;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] alu_res;
  logic [1:0]        fin_status;
  logic [1:0]        flag_code;
  logic              flag_any;
  logic              div_done;
  logic [WORD_W-1:0] div_quot;
  logic [WORD_W-1:0] div_rem;

  assign cnt_m1 = cnt_r - 1'b1;
  assign cnt_m2 = cnt_r - 2'd2;

  // Status toward the controller.
  always_comb begin
    sts.is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
    sts.is_divop = (char_r == CH_DIV) || (char_r == CH_MOD);
    sts.is_op    = (char_r == CH_ADD) || (char_r == CH_SUB) || (char_r == CH_MUL) ||
                   sts.is_divop;
    sts.full     = cnt_r == CNT_W'(STACK_DEPTH);
    sts.lt2      = cnt_r < CNT_W'(2);
    sts.rhs_zero = rhs_r == '0;
    sts.div_done = div_done;
    sts.last     = last_r;
    sts.out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    case (char_r)
      CH_ADD:  alu_res = lhs_r + rhs_r;
      CH_SUB:  alu_res = lhs_r - rhs_r;
      default: alu_res = lhs_r * rhs_r;
    endcase
  end

  // Stack memory: one write port, one registered read port.
  assign rd_en   = cmd.rd_top || cmd.rd_second;
  assign rd_addr = cmd.rd_top ? cnt_m1[IDX_W-1:0] : cnt_m2[IDX_W-1:0];
  assign wr_en   = cmd.push || cmd.write_res;
  assign wr_addr = cmd.push ? cnt_r[IDX_W-1:0] : cnt_m2[IDX_W-1:0];
  assign wr_data = cmd.push ? WORD_W'(char_r - CH_ZERO) : res_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lhs_r),
    .divisor  (rhs_r),
    .done     (div_done),
    .quot     (div_quot),
    .remd     (div_rem)
  );

  // An empty stack at the end gives underflow unless an earlier error holds.
  always_comb begin
    if (err_r != ST_OK) begin
      fin_status = err_r;
    end else if (cnt_r == '0) begin
      fin_status = ST_UNDER;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    flag_any  = cmd.flag_over || cmd.flag_under || cmd.flag_divz;
    flag_code = cmd.flag_over ? ST_OVER : (cmd.flag_under ? ST_UNDER : ST_DIVZ);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_code;
      last_r <= in_end_of_expr;
    end
    if (cmd.cap_rhs) begin
      rhs_r <= rd_q_r;
    end
    if (cmd.cap_lhs) begin
      lhs_r <= rd_q_r;
    end
    if (cmd.alu_take) begin
      res_r <= alu_res;
    end else if (cmd.div_take) begin
      res_r <= (char_r == CH_MOD) ? div_rem : div_quot;
    end
    if (cmd.emit) begin
      out_status_r <= fin_status;
      out_value_r  <= (fin_status == ST_OK) ? rd_q_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        cnt_r <= '0;
        err_r <= ST_OK;
      end else begin
        if (cmd.push) begin
          cnt_r <= cnt_r + 1'b1;
        end else if (cmd.write_res) begin
          cnt_r <= cnt_m1;
        end
        if (flag_any && (err_r == ST_OK)) begin
          err_r <= flag_code;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ----- hw/rtl/pfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfe_ctrl
// Controller: sequences each request through decode, operand reads, the
// ALU or divider, the stack write-back and the end-of-expression result.
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfe_pkg::pfe_sts_t sts,
  output pfe_pkg::pfe_cmd_t cmd
);
  import pfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_RHS,
    S_RD_LHS,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_FIN_CHK,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_digit) begin
          if (sts.full) begin
            cmd.flag_over = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
          state_nxt = S_FIN_CHK;
        end else if (sts.is_op) begin
          if (sts.lt2) begin
            cmd.flag_under = 1'b1;
            state_nxt      = S_FIN_CHK;
          end else begin
            cmd.rd_top = 1'b1;
            state_nxt  = S_RD_RHS;
          end
        end else begin
          state_nxt = S_FIN_CHK;
        end
      end
      S_RD_RHS: begin
        cmd.cap_rhs   = 1'b1;
        cmd.rd_second = 1'b1;
        state_nxt     = S_RD_LHS;
      end
      S_RD_LHS: begin
        cmd.cap_lhs = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_divop) begin
          if (sts.rhs_zero) begin
            cmd.flag_divz = 1'b1;
            state_nxt     = S_FIN_CHK;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.alu_take = 1'b1;
          state_nxt    = S_WRITE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_res = 1'b1;
        state_nxt     = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        if (sts.last) begin
          // The top is read even for an empty stack; the value is then dropped.
          cmd.rd_top = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse-Polish evaluator fed one character per request.
// ----------------------------------------------------------------------------
// The block takes one character at a time and works on it alone: a digit or
// an ignored character passes through decode and the end check before the
// next can be accepted; + - and * add two reads of the operand stack over
// its single read port, one ALU step and one write-back; / and % wait on
// the iterative divider, which produces one quotient bit per cycle.
// For the character marked as the end of the expression, the top of the
// stack is read, then the result register is loaded once it is free; a
// new character is accepted while that result waits to be taken, and only
// the next result waits for the register to free up. The status is sticky
// per expression: 0 ok, 1 stack underflow, 2 stack overflow, 3 divide by
// zero, and the value reads zero whenever the status is not ok.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_expr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);
  import pfe_pkg::*;

  pfe_cmd_t cmd;
  pfe_sts_t sts;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfe_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_char_code   (in_char_code),
    .in_end_of_expr (in_end_of_expr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_status     (out_status)
  );

endmodule

// ----- test/postfix_result_checker.sv -----
// ----------------------------------------------------------------------------
// postfix_result_checker
// Watches both channels of the postfix evaluator and checks its results.
// ----------------------------------------------------------------------------
// Every accepted character is run through a local operand stack with its own
// sticky status. An end-of-expression character queues the value and status
// the block must return. Each accepted result is compared with the oldest
// queued one. The mismatch count and the number of results still due are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module postfix_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_expr,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_value,
  input  logic [1:0]         out_status,
  output int                 mismatches,
  output int                 pending
);
  import pfe_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } expr_result_t;

  expr_result_t      results_due[$];
  expr_result_t      oldest_due;
  logic [WORD_W-1:0] operands [STACK_DEPTH];
  int                depth;
  logic [1:0]        held_status = ST_OK;
  int                results_seen;

  // Only the first error of an expression is kept.
  task automatic hold_error(input logic [1:0] code);
    if (held_status == ST_OK) held_status = code;
  endtask

  task automatic apply_operator(input logic [7:0] op);
    logic [WORD_W-1:0] rhs, lhs, res;
    longint            a, b;
    if (depth < 2) begin
      hold_error(ST_UNDER);
      return;
    end
    rhs = operands[depth-1];
    lhs = operands[depth-2];
    if ((op == CH_DIV || op == CH_MOD) && rhs == '0) begin
      hold_error(ST_DIVZ);
      return;
    end
    // Dividing in 64 bits lets the most negative value over -1 wrap cleanly.
    a = $signed(lhs);
    b = $signed(rhs);
    case (op)
      CH_ADD:  res = lhs + rhs;
      CH_SUB:  res = lhs - rhs;
      CH_MUL:  res = lhs * rhs;
      CH_DIV:  res = 32'(a / b);
      default: res = 32'(a % b);
    endcase
    depth = depth - 1;
    operands[depth-1] = res;
  endtask

  task automatic evaluate_char(input logic [7:0] ch, input logic last);
    expr_result_t res;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (depth >= STACK_DEPTH) begin
        hold_error(ST_OVER);
      end else begin
        operands[depth] = 32'(ch - CH_ZERO);
        depth = depth + 1;
      end
    end else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV ||
                 ch == CH_MOD) begin
      apply_operator(ch);
    end
    if (last) begin
      res.value = '0;
      if (depth == 0) hold_error(ST_UNDER);
      else res.value = operands[depth-1];
      res.status = held_status;
      if (held_status != ST_OK) res.value = '0;
      results_due.push_back(res);
      depth       = 0;
      held_status = ST_OK;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // A result can never belong to a request taken at the same edge, so
      // results are matched before the new request is evaluated.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with none due: value %0d status %0d",
                     results_seen, out_value, out_status);
        end else begin
          oldest_due = results_due.pop_front();
          if (out_value !== oldest_due.value || out_status !== oldest_due.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected value %0d status %0d, got value %0d status %0d",
                       results_seen, oldest_due.value, oldest_due.status,
                       out_value, out_status);
          end
        end
      end
      if (in_valid && !in_stall) evaluate_char(in_char_code, in_end_of_expr);
    end
    pending = results_due.size();
  end

endmodule

// ----- test/postfix_expression_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// Stimulus and verdict for the postfix expression evaluator.
// ----------------------------------------------------------------------------
// A directed set of expressions covers every operator, negative division,
// the sticky errors, leftover entries, an empty stack and the most negative
// value divided by minus one. Random expressions follow, most of them well
// formed, with noise, broken sequences and overflow runs mixed in. Both
// channels idle at random; a separate checker does the comparison.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;
  import pfe_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;

  // Builds 2^31, which reads back as the most negative 32-bit value.
  localparam string MOST_NEG = "8888***8888****288***";

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code   = '0;
  logic               in_end_of_expr = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic signed [31:0] out_value;
  logic [1:0]         out_status;

  int   mismatches;
  int   pending;
  int   cycles        = 0;
  int   counted_items = 0;
  int   stall_left    = 0;
  int   stall_roll;
  int   mix_roll;
  logic calm          = 1'b0;

  postfix_expression_evaluator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_expr (in_end_of_expr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_status     (out_status)
  );

  postfix_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_expr (in_end_of_expr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_status     (out_status),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (calm || stall_roll < 55) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else if (stall_roll < 92) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(9, 39);
      end
    end
  end

  function automatic logic is_operator(input logic [7:0] ch);
    return ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV || ch == CH_MOD;
  endfunction

  function automatic logic [7:0] op_char(input int k);
    case (k)
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_MOD;
    endcase
  endfunction

  function automatic logic [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || is_operator(c));
    return c;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_item(input logic [7:0] ch, input logic last);
    int gap;
    in_valid       <= 1'b1;
    in_char_code   <= ch;
    in_end_of_expr <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    counted_items++;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_seq(input logic [7:0] seq[$], input logic close);
    for (int i = 0; i < seq.size(); i++)
      send_item(seq[i], close && i == seq.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] seq[$];
    for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
    send_seq(seq, 1'b1);
  endtask

  task automatic wait_for_results();
    if (in_valid) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random operands and operators in valid postfix order; once in a while
  // extra entries are left on the stack at the end.
  task automatic send_wellformed();
    logic [7:0] seq[$];
    int         operands, pushed, depth, keep;
    operands = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    keep     = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
    pushed   = 0;
    depth    = 0;
    while (pushed < operands || depth > keep) begin
      if (depth >= 2 && (pushed == operands || $urandom_range(0, 2) == 0)) begin
        seq.push_back(op_char($urandom_range(0, 4)));
        depth--;
      end else begin
        seq.push_back(digit_char());
        pushed++;
        depth++;
      end
      if ($urandom_range(0, 11) == 0) seq.push_back(noise_char());
    end
    send_seq(seq, 1'b1);
  endtask

  // Arbitrary characters; the expression is sometimes left open.
  task automatic send_noise();
    logic [7:0] seq[$];
    int         len, r;
    len = $urandom_range(1, 24);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 40) seq.push_back(digit_char());
      else if (r < 70) seq.push_back(op_char($urandom_range(0, 4)));
      else seq.push_back(8'($urandom_range(0, 255)));
    end
    send_seq(seq, $urandom_range(0, 9) < 7);
  endtask

  task automatic send_overflow();
    logic [7:0] seq[$];
    repeat ($urandom_range(17, 20)) seq.push_back(digit_char());
    repeat ($urandom_range(0, 3)) seq.push_back(op_char($urandom_range(0, 4)));
    send_seq(seq, 1'b1);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("7");
    send_text("95+3*4-7/3%");
    send_text("09-4/");
    send_text("09-4%");
    send_text("9*");
    send_text("50/");
    send_text("+50/");
    send_text("123");
    send_text({MOST_NEG, "01-/"});
    send_text({MOST_NEG, "01-%"});
    send_text("98765432109876543");
    // Ignored characters at both ends of the code range, ending on an
    // empty stack.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    wait_for_results();
    repeat ($urandom_range(5, 20)) @(negedge clk);

    while (counted_items < RANDOM_ITEMS) begin
      calm <= ($urandom_range(0, 6) == 0);
      mix_roll = $urandom_range(0, 99);
      if (mix_roll < 75) send_wellformed();
      else if (mix_roll < 90) send_noise();
      else send_overflow();
      if ($urandom_range(0, 29) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
